// ----- rtl/core/cst_pkg.sv -----
// ----------------------------------------------------------------------------
// cst_pkg
// Types, character codes and record formats shared by the tokenizer files.
// ----------------------------------------------------------------------------
package cst_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_TEXT,
    MODE_DQ,
    MODE_SQ
  } mode_t;

  localparam logic [1:0] KIND_TOKEN = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] TT_LBRACE = 3'd0;
  localparam logic [2:0] TT_RBRACE = 3'd1;
  localparam logic [2:0] TT_LBRACK = 3'd2;
  localparam logic [2:0] TT_RBRACK = 3'd3;
  localparam logic [2:0] TT_SEPARATOR = 3'd4;
  localparam logic [2:0] TT_EQUAL  = 3'd5;
  localparam logic [2:0] TT_COLON  = 3'd6;
  localparam logic [2:0] TT_TEXT   = 3'd7;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam int MAX_RECS = 3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  token_type;
    logic [15:0] start;
    logic [15:0] length;
  } rec_t;

  // Records caused by one byte, packed from slot 0 upward.
  typedef struct packed {
    logic [1:0]                count;
    rec_t [MAX_RECS-1:0]       recs;
  } batch_t;

  function automatic logic is_ws(logic [7:0] c);
    return c inside {CH_SPACE, [CH_TAB:CH_CR]};
  endfunction

  function automatic logic is_single(logic [7:0] c);
    return c inside {CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK, CH_COMMA, CH_EQUAL,
                     CH_COLON};
  endfunction

  function automatic logic [2:0] single_type(logic [7:0] c);
    logic [2:0] t;
    case (c)
      CH_LBRACE: t = TT_LBRACE;
      CH_RBRACE: t = TT_RBRACE;
      CH_LBRACK: t = TT_LBRACK;
      CH_RBRACK: t = TT_RBRACK;
      CH_COMMA:  t = TT_SEPARATOR;
      CH_EQUAL:  t = TT_EQUAL;
      CH_COLON:  t = TT_COLON;
      default:   t = TT_TEXT;
    endcase
    return t;
  endfunction

endpackage

// ----- rtl/core/cst_in_if.sv -----
// ----------------------------------------------------------------------------
// cst_in_if
// Byte channel into the tokenizer: one string byte and its final flag a beat.
// ----------------------------------------------------------------------------
interface cst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       final_byte;

  modport source (output valid, output ch, output final_byte, input ready);
  modport sink   (input valid, input ch, input final_byte, output ready);
endinterface

// ----- rtl/core/cst_out_if.sv -----
// ----------------------------------------------------------------------------
// cst_out_if
// Token record channel out of the tokenizer: one record a beat.
// ----------------------------------------------------------------------------
interface cst_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  token_type;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic        last_result;

  modport source (output valid, output kind, output token_type, output token_start,
                  output token_length, output last_result, input ready);
  modport sink   (input valid, input kind, input token_type, input token_start,
                  input token_length, input last_result, output ready);
endinterface

// ----- rtl/core/cst_scan.sv -----
// ----------------------------------------------------------------------------
// cst_scan
// Scanner state and the records that one byte causes, formed in one pass.
// ----------------------------------------------------------------------------
module cst_scan #(
  parameter longint unsigned MAX_LEN = 65536
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  logic [7:0]      ch,
  input  logic            final_byte,
  output cst_pkg::batch_t batch
);
  import cst_pkg::*;

  localparam int PW = $clog2(MAX_LEN);
  localparam logic [PW-1:0] POS_MAX = PW'(MAX_LEN - 64'd1);

  mode_t         mode, mode_next;
  logic [PW-1:0] position, position_next;
  logic [PW-1:0] token_begin, token_begin_next;
  logic          started, started_next;

  logic          ws, ends_text, st;
  logic          close_text, close_quote, single_tok, flush_text, open_quote;
  mode_t         mode_a;
  logic [PW:0]   p1;
  logic [PW-1:0] p_sat;

  function automatic logic [PW-1:0] sat_len(logic [PW:0] endx, logic [PW-1:0] begin_pos);
    logic [PW:0] diff;
    diff = endx - {1'b0, begin_pos};
    return (diff > {1'b0, POS_MAX}) ? POS_MAX : diff[PW-1:0];
  endfunction

  function automatic logic [15:0] to16(logic [PW-1:0] v);
    logic [PW+15:0] w;
    w = {16'b0, v};
    return w[15:0];
  endfunction

  function automatic rec_t make_rec(logic [1:0] k, logic [2:0] t, logic [15:0] s,
                                    logic [15:0] l);
    rec_t r;
    r.kind       = k;
    r.token_type = t;
    r.start      = s;
    r.length     = l;
    return r;
  endfunction

  always_comb begin
    ws        = is_ws(ch);
    ends_text = ws || (is_single(ch) && ch != CH_COLON);
    st        = started || !ws;
    p1        = {1'b0, position} + {{PW{1'b0}}, 1'b1};
    p_sat     = (p1 > {1'b0, POS_MAX}) ? POS_MAX : p1[PW-1:0];

    close_text = st && mode == MODE_TEXT && ends_text;
    mode_a     = close_text ? MODE_IDLE : mode;

    close_quote = st && ((mode_a == MODE_DQ && ch == CH_DQUOTE) ||
                         (mode_a == MODE_SQ && ch == CH_SQUOTE));
    single_tok  = st && mode_a == MODE_IDLE && !ws && is_single(ch);

    mode_next        = mode_a;
    token_begin_next = token_begin;
    if (close_quote) begin
      mode_next = MODE_IDLE;
    end else if (st && mode_a == MODE_IDLE && !ws && !is_single(ch)) begin
      token_begin_next = position;
      if (ch == CH_DQUOTE) begin
        mode_next = MODE_DQ;
      end else if (ch == CH_SQUOTE) begin
        mode_next = MODE_SQ;
      end else begin
        mode_next = MODE_TEXT;
      end
    end

    flush_text = final_byte && st && mode_next == MODE_TEXT;
    open_quote = final_byte && st && (mode_next == MODE_DQ || mode_next == MODE_SQ);

    // Records go in the order the scanner finds them.
    batch = '0;
    if (close_text) begin
      batch.recs[batch.count] = make_rec(KIND_TOKEN, TT_TEXT, to16(token_begin),
                                         to16(sat_len({1'b0, position}, token_begin)));
      batch.count = batch.count + 2'd1;
    end
    if (close_quote) begin
      batch.recs[batch.count] = make_rec(KIND_TOKEN, TT_TEXT, to16(token_begin),
                                         to16(sat_len(p1, token_begin)));
      batch.count = batch.count + 2'd1;
    end
    if (single_tok) begin
      batch.recs[batch.count] = make_rec(KIND_TOKEN, single_type(ch), to16(position),
                                         16'd1);
      batch.count = batch.count + 2'd1;
    end
    if (flush_text) begin
      batch.recs[batch.count] = make_rec(KIND_TOKEN, TT_TEXT, to16(token_begin_next),
                                         to16(sat_len(p1, token_begin_next)));
      batch.count = batch.count + 2'd1;
    end
    if (open_quote) begin
      batch.recs[batch.count] = make_rec(KIND_ERROR, TT_TEXT, to16(token_begin_next),
                                         16'd0);
      batch.count = batch.count + 2'd1;
    end
    if (final_byte) begin
      batch.recs[batch.count] = make_rec(KIND_END, TT_LBRACE, 16'd0, 16'd0);
      batch.count = batch.count + 2'd1;
    end

    started_next  = st;
    position_next = st ? p_sat : position;
    if (final_byte) begin
      mode_next        = MODE_IDLE;
      position_next    = '0;
      token_begin_next = '0;
      started_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      position    <= '0;
      token_begin <= '0;
      started     <= 1'b0;
    end else if (take) begin
      mode        <= mode_next;
      position    <= position_next;
      token_begin <= token_begin_next;
      started     <= started_next;
    end
  end

  // Before the first non-whitespace byte nothing may be open or counted.
  a_idle_before_start: assert property (@(posedge clk) disable iff (rst)
    !started |-> (mode == MODE_IDLE && position == '0))
    else $error("scanner left idle before the string started");

  // An open token never begins after the current position.
  a_begin_order: assert property (@(posedge clk) disable iff (rst)
    token_begin <= position)
    else $error("token begin lies beyond the current position");

  // The position counter stops at its saturation point.
  a_pos_cap: assert property (@(posedge clk) disable iff (rst)
    position <= POS_MAX)
    else $error("position ran past its saturation point");

endmodule

// ----- rtl/core/config_spec_tokenizer.sv -----
// ----------------------------------------------------------------------------
// config_spec_tokenizer
// Streaming tokenizer that turns string bytes into token records.
// ----------------------------------------------------------------------------
// Each accepted byte updates the scanner and loads the zero to three records
// it causes into a result buffer in the same cycle; records then leave one
// per cycle in order while tokens.ready is high, the last one of a byte
// flagged by last_result. A byte is taken every cycle as long as at most one
// record is pending and it leaves in that cycle, so plain text streams at
// one byte per cycle; a byte that causes two or three records holds the
// input until all but its last record have left the buffer's single port.
// Positions and lengths saturate at MAX_LEN-1, reported in their low 16 bits.
module config_spec_tokenizer #(
  parameter longint unsigned MAX_LEN = 65536
) (
  input logic       clk,
  input logic       rst,
  cst_in_if.sink    chars,
  cst_out_if.source tokens
);
  import cst_pkg::*;

  batch_t     batch;
  rec_t       slots [MAX_RECS];
  logic [1:0] rem;
  logic [1:0] idx;
  logic       take;
  logic       give;

  cst_scan #(
    .MAX_LEN (MAX_LEN)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .ch         (chars.ch),
    .final_byte (chars.final_byte),
    .batch      (batch)
  );

  assign chars.ready = (rem == 2'd0) || (rem == 2'd1 && tokens.ready);
  assign take        = chars.valid && chars.ready;
  assign give        = tokens.valid && tokens.ready;

  assign tokens.valid        = rem != 2'd0;
  assign tokens.kind         = slots[idx].kind;
  assign tokens.token_type   = slots[idx].token_type;
  assign tokens.token_start  = slots[idx].start;
  assign tokens.token_length = slots[idx].length;
  assign tokens.last_result  = rem == 2'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 2'd0;
      idx <= 2'd0;
    end else if (take) begin
      rem <= batch.count;
      idx <= 2'd0;
    end else if (give) begin
      rem <= rem - 2'd1;
      // The read pointer stays on the last record once the batch drains.
      if (rem != 2'd1) begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < MAX_RECS; i++) begin
        slots[i] <= batch.recs[i];
      end
    end
  end

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, idx} + {1'b0, rem}) <= 3'd3)
    else $error("result pointer runs past the loaded records");

  a_final_ends: assert property (@(posedge clk) disable iff (rst)
    (take && chars.final_byte) |=>
      (rem != 2'd0 && slots[rem - 2'd1].kind == KIND_END))
    else $error("final byte did not close with an end record");

  a_error_not_last: assert property (@(posedge clk) disable iff (rst)
    (tokens.valid && tokens.kind == KIND_ERROR) |-> !tokens.last_result)
    else $error("quote error record not followed by an end record");

endmodule

// ----- dv/config_spec_tokenizer_tb.sv -----
// ----------------------------------------------------------------------------
// config_spec_tokenizer_tb
// Self-checking bench for the streaming config-string tokenizer. A table of
// short strings covers every token kind, both quote styles, an unterminated
// quote and a blank string. Random strings follow with the byte and record
// sides stalling at random. Every record is compared with a cycle-free model.
// ----------------------------------------------------------------------------
module config_spec_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cst_pkg::*;

  localparam int unsigned LEN_CAP     = 65535;
  localparam int          STALL_LIMIT = 2000;
  localparam int          HOLD_CYCLES = 250;
  localparam int          PHASE_BYTES = 140;
  localparam int          PRINT_LIMIT = 30;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  token_type;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
  } tok_rec_t;

  // One byte beat; when typed is set, first replaces the model's first record.
  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    logic       typed;
    tok_rec_t   first;
  } beat_t;

  localparam tok_rec_t NO_REC = '0;

  localparam beat_t DIR_BEATS [25] = '{
    '{CH_SPACE,  1'b0, 1'b0, NO_REC},
    '{CH_TAB,    1'b0, 1'b0, NO_REC},
    '{CH_LBRACE, 1'b0, 1'b1, '{KIND_TOKEN, TT_LBRACE, 16'd0, 16'd1, 1'b1}},
    '{CH_RBRACE, 1'b0, 1'b0, NO_REC},
    '{CH_LBRACK, 1'b0, 1'b0, NO_REC},
    '{CH_RBRACK, 1'b0, 1'b0, NO_REC},
    '{CH_COMMA,  1'b0, 1'b0, NO_REC},
    '{CH_EQUAL,  1'b0, 1'b0, NO_REC},
    '{CH_COLON,  1'b0, 1'b0, NO_REC},
    '{8'h61,     1'b0, 1'b0, NO_REC},
    '{CH_COLON,  1'b0, 1'b0, NO_REC},
    '{CH_DQUOTE, 1'b0, 1'b0, NO_REC},
    '{8'hFF,     1'b0, 1'b0, NO_REC},
    '{CH_SPACE,  1'b0, 1'b0, NO_REC},
    '{CH_DQUOTE, 1'b0, 1'b0, NO_REC},
    '{CH_COMMA,  1'b0, 1'b0, NO_REC},
    '{CH_DQUOTE, 1'b0, 1'b0, NO_REC},
    '{CH_SQUOTE, 1'b0, 1'b0, NO_REC},
    '{CH_DQUOTE, 1'b0, 1'b0, NO_REC},
    '{8'h00,     1'b1, 1'b1, '{KIND_ERROR, TT_TEXT, 16'd15, 16'd0, 1'b0}},
    '{CH_CR,     1'b0, 1'b0, NO_REC},
    '{CH_SPACE,  1'b1, 1'b1, '{KIND_END, 3'd0, 16'd0, 16'd0, 1'b1}},
    '{8'h78,     1'b0, 1'b0, NO_REC},
    '{8'h80,     1'b0, 1'b0, NO_REC},
    '{CH_COMMA,  1'b1, 1'b1, '{KIND_TOKEN, TT_TEXT, 16'd0, 16'd2, 1'b0}}
  };

  logic clk;
  logic rst;

  cst_in_if  chars_if ();
  cst_out_if tokens_if ();

  config_spec_tokenizer dut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_if),
    .tokens (tokens_if)
  );

  // Model state.
  mode_t       cur_mode;
  int unsigned cur_pos;
  int unsigned open_begin;
  bit          seen_text;

  tok_rec_t    byte_tokens[$];
  tok_rec_t    pending_tokens[$];
  beat_t       beat_notes[$];
  logic [7:0]  str_bytes[$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  int mismatches;
  int bytes_sent;
  int strings_sent;
  int records_seen;
  int quote_errors_seen;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit punct_kind(input logic [7:0] c, output logic [2:0] tt);
    bit hit;
    hit = 1'b1;
    case (c)
      CH_LBRACE: tt = TT_LBRACE;
      CH_RBRACE: tt = TT_RBRACE;
      CH_LBRACK: tt = TT_LBRACK;
      CH_RBRACK: tt = TT_RBRACK;
      CH_COMMA:  tt = TT_SEPARATOR;
      CH_EQUAL:  tt = TT_EQUAL;
      CH_COLON:  tt = TT_COLON;
      default: begin
        tt  = TT_TEXT;
        hit = 1'b0;
      end
    endcase
    return hit;
  endfunction

  // A colon or a quote does not close a text token.
  function automatic bit cuts_text(logic [7:0] c);
    logic [2:0] tt;
    return is_blank(c) || (punct_kind(c, tt) && c != CH_COLON);
  endfunction

  function automatic logic [15:0] clip_len(int unsigned endx, int unsigned begin_pos);
    int unsigned n;
    n = endx >= begin_pos ? endx - begin_pos : 0;
    return 16'(n > LEN_CAP ? LEN_CAP : n);
  endfunction

  function automatic void add_token(logic [1:0] kind, logic [2:0] tt, int unsigned start,
                                    logic [15:0] len);
    byte_tokens.push_back('{kind, tt, 16'(start), len, 1'b0});
  endfunction

  function automatic void reset_scanner();
    cur_mode   = MODE_IDLE;
    cur_pos    = 0;
    open_begin = 0;
    seen_text  = 1'b0;
  endfunction

  // Fills byte_tokens with the records one byte causes and advances the state.
  function automatic void tokenize_byte(logic [7:0] c, logic fin);
    int unsigned p;
    logic [2:0]  tt;
    logic [7:0]  closer;
    byte_tokens.delete();
    if (!seen_text && !is_blank(c)) seen_text = 1'b1;
    if (seen_text) begin
      p = cur_pos;
      if (cur_mode == MODE_TEXT && cuts_text(c)) begin
        add_token(KIND_TOKEN, TT_TEXT, open_begin, clip_len(p, open_begin));
        cur_mode = MODE_IDLE;
      end
      if (cur_mode == MODE_DQ || cur_mode == MODE_SQ) begin
        closer = cur_mode == MODE_DQ ? CH_DQUOTE : CH_SQUOTE;
        if (c == closer) begin
          add_token(KIND_TOKEN, TT_TEXT, open_begin, clip_len(p + 1, open_begin));
          cur_mode = MODE_IDLE;
        end
      end else if (cur_mode == MODE_IDLE && !is_blank(c)) begin
        if (punct_kind(c, tt)) begin
          add_token(KIND_TOKEN, tt, p, 16'd1);
        end else begin
          open_begin = p;
          if (c == CH_DQUOTE) cur_mode = MODE_DQ;
          else if (c == CH_SQUOTE) cur_mode = MODE_SQ;
          else cur_mode = MODE_TEXT;
        end
      end
      if (fin) begin
        if (cur_mode == MODE_TEXT)
          add_token(KIND_TOKEN, TT_TEXT, open_begin, clip_len(p + 1, open_begin));
        else if (cur_mode == MODE_DQ || cur_mode == MODE_SQ)
          add_token(KIND_ERROR, TT_TEXT, open_begin, 16'd0);
      end
      cur_pos = p + 1 > LEN_CAP ? LEN_CAP : p + 1;
    end
    if (fin) begin
      add_token(KIND_END, 3'd0, 0, 16'd0);
      reset_scanner();
    end
    if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size()-1].last = 1'b1;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    if (mismatches < PRINT_LIMIT)
      $display("MISMATCH t=%0t record %0d: %s got %0h expected %0h",
               $time, records_seen, what, got, want);
    mismatches++;
  endtask

  // Byte side and record side sampled at the same edge, bytes first.
  always @(posedge clk) begin : scoreboard
    beat_t    note;
    tok_rec_t got;
    tok_rec_t want;
    if (!rst) begin
      if (chars_if.valid && chars_if.ready) begin
        note = beat_notes.size() > 0 ? beat_notes.pop_front() : '0;
        tokenize_byte(chars_if.ch, chars_if.final_byte);
        if (note.typed) begin
          if (byte_tokens.size() == 0) byte_tokens.push_back(note.first);
          else byte_tokens[0] = note.first;
        end
        foreach (byte_tokens[i]) pending_tokens.push_back(byte_tokens[i]);
      end
      if (tokens_if.valid && tokens_if.ready) begin
        got = '{tokens_if.kind, tokens_if.token_type, tokens_if.token_start,
                tokens_if.token_length, tokens_if.last_result};
        if (got.kind == KIND_ERROR) quote_errors_seen++;
        if (pending_tokens.size() == 0) begin
          report_mismatch("record with nothing pending", got, 0);
        end else begin
          want = pending_tokens.pop_front();
          if (got.kind != want.kind) report_mismatch("kind", got.kind, want.kind);
          if (got.token_type != want.token_type)
            report_mismatch("token_type", got.token_type, want.token_type);
          if (got.start != want.start) report_mismatch("token_start", got.start, want.start);
          if (got.length != want.length)
            report_mismatch("token_length", got.length, want.length);
          if (got.last != want.last) report_mismatch("last_result", got.last, want.last);
        end
        records_seen++;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((chars_if.valid && chars_if.ready) || (tokens_if.valid && tokens_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no beat on either channel for %0d cycles", STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // Record side: random stalls, or a counted hold-off when one is requested.
  initial begin : record_sink
    tokens_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        tokens_if.ready <= 1'b0;
      end else begin
        tokens_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_beat(logic [7:0] c, logic fin, logic typed, tok_rec_t first);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      chars_if.valid <= 1'b0;
      @(posedge clk);
    end
    beat_notes.push_back('{c, fin, typed, first});
    chars_if.valid      <= 1'b1;
    chars_if.ch         <= c;
    chars_if.final_byte <= fin;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
    bytes_sent++;
    if (fin) strings_sent++;
  endtask

  task automatic wait_for_drain();
    chars_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_tokens.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_blank();
    return $urandom_range(0, 3) == 0 ? CH_SPACE : 8'($urandom_range(9, 13));
  endfunction

  function automatic logic [7:0] pick_punct();
    case ($urandom_range(0, 6))
      0:       return CH_LBRACE;
      1:       return CH_RBRACE;
      2:       return CH_LBRACK;
      3:       return CH_RBRACK;
      4:       return CH_COMMA;
      5:       return CH_EQUAL;
      default: return CH_COLON;
    endcase
  endfunction

  // A leading byte must not turn the token into a colon or a quoted one.
  function automatic logic [7:0] pick_text_char(bit lead);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (cuts_text(c) || (lead && (c == CH_COLON || c == CH_DQUOTE || c == CH_SQUOTE)));
    return c;
  endfunction

  function automatic logic [7:0] pick_not(logic [7:0] q);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == q);
    return c;
  endfunction

  task automatic build_string();
    logic [7:0] q;
    str_bytes.delete();
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 4)) str_bytes.push_back(pick_blank());
      return;
    end
    if ($urandom_range(0, 1)) repeat ($urandom_range(1, 3)) str_bytes.push_back(pick_blank());
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 9))
        0, 1: str_bytes.push_back(pick_punct());
        2, 3, 4: begin
          str_bytes.push_back(pick_text_char(1'b1));
          repeat ($urandom_range(0, 6)) str_bytes.push_back(pick_text_char(1'b0));
        end
        5, 6: begin
          q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
          str_bytes.push_back(q);
          repeat ($urandom_range(0, 5)) str_bytes.push_back(pick_not(q));
          str_bytes.push_back(q);
        end
        7: str_bytes.push_back(8'($urandom_range(0, 255)));
        default: repeat ($urandom_range(1, 3)) str_bytes.push_back(pick_blank());
      endcase
      if ($urandom_range(0, 2) == 0) str_bytes.push_back(pick_blank());
    end
    // Now and then leave a quote open at the end of the string.
    if ($urandom_range(0, 9) == 0) begin
      q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
      str_bytes.push_back(q);
      repeat ($urandom_range(0, 3)) str_bytes.push_back(pick_not(q));
    end
    if ($urandom_range(0, 3) == 0) str_bytes.push_back(pick_blank());
  endtask

  task automatic send_string();
    foreach (str_bytes[i]) send_beat(str_bytes[i], i == str_bytes.size() - 1, 1'b0, NO_REC);
  endtask

  task automatic run_phase(int s_pct, int r_pct, bit with_hold);
    int first_byte;
    bit held;
    first_byte    = bytes_sent;
    held          = 1'b0;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    while (bytes_sent - first_byte < PHASE_BYTES) begin
      // The byte side keeps offering while the record side is held off.
      if (with_hold && !held && bytes_sent - first_byte > 60) begin
        hold_left = HOLD_CYCLES;
        held      = 1'b1;
      end
      build_string();
      send_string();
    end
    wait_for_drain();
  endtask

  initial begin : stimulus
    rst                 <= 1'b1;
    chars_if.valid      <= 1'b0;
    chars_if.ch         <= 8'h00;
    chars_if.final_byte <= 1'b0;
    send_idle_pct = 20;
    recv_idle_pct = 52;
    hold_left     = 0;
    reset_scanner();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < $size(DIR_BEATS); i++)
      send_beat(DIR_BEATS[i].ch, DIR_BEATS[i].fin, DIR_BEATS[i].typed, DIR_BEATS[i].first);

    run_phase(20, 52, 1'b1);
    run_phase(52, 20, 1'b0);
    run_phase(0, 0, 1'b0);
    wait_for_drain();
    repeat (16) @(posedge clk);

    if (pending_tokens.size() != 0)
      report_mismatch("records never produced", pending_tokens.size(), 0);

    $display("Run covered %0d strings in %0d bytes, %0d records checked, %0d open-quote errors.",
             strings_sent, bytes_sent, records_seen, quote_errors_seen);
    $display("Both sides stalled in turn, the record side was held off once while bytes kept");
    $display("coming, and the byte side waited for a full drain after each phase.");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/cst_pkg.sv
rtl/core/cst_in_if.sv
rtl/core/cst_out_if.sv
rtl/core/cst_scan.sv
rtl/core/config_spec_tokenizer.sv
dv/config_spec_tokenizer_tb.sv
